[hw/rtl/fmc_pkg.sv]
// ----------------------------------------------------------------------------
// fmc_pkg: shared types and tables of the flashlight mode controller
// Word layouts, register indexes, mode tables and the battery blink count.
// ----------------------------------------------------------------------------
`default_nettype none

package fmc_pkg;

   // register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_GROUP     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEMORY_ENABLED = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_LIMIT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEDIUM_LIMIT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TURBO_LIMIT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_VOLTAGE    = 3'd5;
   localparam int unsigned CSR_DATA_W = 8;

   // register reset values
   localparam logic [7:0] SHORT_LIMIT_RESET  = 8'd190;
   localparam logic [7:0] MEDIUM_LIMIT_RESET = 8'd94;
   localparam logic [7:0] TURBO_LIMIT_RESET  = 8'd90;
   localparam logic [7:0] LOW_VOLTAGE_RESET  = 8'd129;

   // operation codes
   localparam logic OP_POWER_UP = 1'b0;
   localparam logic OP_LOOP     = 1'b1;

   // mode kinds
   localparam logic [1:0] KIND_SOLID    = 2'd0;
   localparam logic [1:0] KIND_TACTICAL = 2'd1;
   localparam logic [1:0] KIND_BIKING   = 2'd2;
   localparam logic [1:0] KIND_BATTERY  = 2'd3;

   localparam logic [4:0] FAST_MASK        = 5'h1f;
   localparam logic [4:0] CONFIG_THRESHOLD = 5'h0f;
   localparam logic [7:0] TURBO_LEVEL      = 8'd255;
   localparam logic [3:0] LOW_SAMPLES_ACT  = 4'd8;
   localparam logic [3:0] SPECIAL_MODES    = 4'd4;
   localparam logic [3:0] SOLID_GROUP0     = 4'd7;
   localparam logic [3:0] SOLID_GROUP1     = 4'd4;
   localparam logic [3:0] LOW_BATT_MODE    = 4'd2;

   localparam logic [7:0] MAIN_TAB [0:1][0:10] = '{
      '{8'd0, 8'd0, 8'd0, 8'd7, 8'd56, 8'd137, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255},
      '{8'd0, 8'd0, 8'd90, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0}
   };
   localparam logic [7:0] ALT_TAB [0:1][0:10] = '{
      '{8'd3, 8'd20, 8'd110, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd20, 8'd230, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
   };
   localparam logic FAST_TAB [0:1][0:10] = '{
      '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}
   };
   localparam logic [1:0] KIND_TAB [0:1][0:10] = '{
      '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd3, 2'd1, 2'd0},
      '{2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0}
   };
   localparam logic [7:0] BATT_THRESH [0:4] = '{8'd138, 8'd162, 8'd176, 8'd186, 8'd195};

   typedef struct packed {
      logic       operation;
      logic [7:0] off_time_reading;
      logic       voltage_valid;
      logic [7:0] battery_reading;
   } req_word_type;

   typedef struct packed {
      logic [3:0] mode_number;
      logic [7:0] main_level;
      logic [7:0] alt_level;
      logic       fast_pwm;
      logic [1:0] mode_kind;
      logic [2:0] blink_count;
      logic       config_entered;
      logic       save_request;
      logic       shut_off;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] main_level;
      logic [7:0] alt_level;
      logic       fast_pwm;
      logic [1:0] mode_kind;
   } entry_type;

   // table entry of a mode; special kinds and out-of-group indexes carry no levels
   function automatic entry_type mode_lookup(input logic group, input logic [3:0] m);
      entry_type  e;
      logic [3:0] total;
      e = '0;
      total = (group ? SOLID_GROUP1 : SOLID_GROUP0) + SPECIAL_MODES;
      if (m < total) begin
         e.mode_kind = KIND_TAB[group][m];
         if (e.mode_kind == KIND_SOLID) begin
            e.main_level = MAIN_TAB[group][m];
            e.alt_level  = ALT_TAB[group][m];
            e.fast_pwm   = (e.main_level == 8'd0 && e.alt_level == 8'd0) ? 1'b0
                                                                        : FAST_TAB[group][m];
         end
      end
      return e;
   endfunction

   // thresholds are ascending, so the count of exceeded ones is the blink count
   function automatic logic [2:0] blink_calc(input logic [7:0] batt);
      logic [2:0] n;
      n = 3'd0;
      for (int i = 0; i < 5; i++) begin
         if (batt > BATT_THRESH[i]) n = n + 3'd1;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/flashlight_mode_controller.sv]
// ----------------------------------------------------------------------------
// flashlight_mode_controller: mode sequencing of a two-channel light driver
// A word passes the input register, then the result register that drives rsp.
// Throughput: one word per cycle while rsp_ready is high, set by the input
// register feeding the result register through one pass of mode logic.
// Reset (synchronous, active high) clears mode state and word valids and
// loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module flashlight_mode_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire fmc_pkg::req_word_type               req_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output fmc_pkg::rsp_word_type                    rsp_word,
   input  wire logic                                csr_wr_en,
   input  wire logic [fmc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [fmc_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import fmc_pkg::*;

   // configuration
   logic       mode_group_ff;
   logic       memory_enabled_ff;
   logic [7:0] short_limit_ff;
   logic [7:0] medium_limit_ff;
   logic [7:0] turbo_limit_ff;
   logic [7:0] low_voltage_ff;

   // mode state
   logic [3:0] mode_index_ff,  mode_index_in;
   logic [4:0] fast_count_ff,  fast_count_in;
   logic [7:0] turbo_ticks_ff, turbo_ticks_in;
   logic [3:0] low_count_ff,   low_count_in;
   logic       powered_down_ff, powered_down_in;

   // pipeline
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      logic [3:0] solid;
      logic [3:0] total;
      logic [3:0] mode_plus;
      entry_type  cur;
      entry_type  fin;
      logic [2:0] blinks;
      logic       cfg;
      logic       save;

      solid     = mode_group_ff ? SOLID_GROUP1 : SOLID_GROUP0;
      total     = solid + SPECIAL_MODES;
      mode_plus = mode_index_ff + 4'd1;
      cur       = mode_lookup(mode_group_ff, mode_index_ff);
      blinks    = 3'd0;
      cfg       = 1'b0;
      save      = 1'b0;

      mode_index_in   = mode_index_ff;
      fast_count_in   = fast_count_ff;
      turbo_ticks_in  = turbo_ticks_ff;
      low_count_in    = low_count_ff;
      powered_down_in = powered_down_ff;

      if (in_word_ff.operation == OP_POWER_UP) begin
         turbo_ticks_in  = 8'd0;
         low_count_in    = 4'd0;
         powered_down_in = 1'b0;
         if (in_word_ff.off_time_reading > short_limit_ff) begin
            fast_count_in = (fast_count_ff + 5'd1) & FAST_MASK;
            mode_index_in = (mode_plus >= solid) ? 4'd0 : mode_plus;
         end else if (in_word_ff.off_time_reading > medium_limit_ff) begin
            fast_count_in = 5'd0;
            if (mode_index_ff == solid) begin
               mode_index_in = 4'd0;
            end else if (mode_index_ff != 4'd0) begin
               mode_index_in = mode_index_ff - 4'd1;
            end else begin
               mode_index_in = total - 4'd1;
            end
         end else begin
            fast_count_in = 5'd0;
            if (!memory_enabled_ff) mode_index_in = 4'd0;
         end
         save = 1'b1;
      end else if (!powered_down_ff) begin
         if (fast_count_ff > CONFIG_THRESHOLD) begin
            fast_count_in = 5'd0;
            mode_index_in = 4'd0;
            cfg           = 1'b1;
            save          = 1'b1;
         end else if (cur.mode_kind == KIND_BATTERY) begin
            blinks = blink_calc(in_word_ff.battery_reading);
         end else if (cur.mode_kind == KIND_SOLID) begin
            turbo_ticks_in = turbo_ticks_ff + 8'd1;
            if (turbo_ticks_in > turbo_limit_ff && cur.main_level == TURBO_LEVEL) begin
               mode_index_in = solid - 4'd2;
               save          = 1'b1;
            end
            fast_count_in = 5'd0;
         end
         if (in_word_ff.voltage_valid) begin
            low_count_in = (in_word_ff.battery_reading < low_voltage_ff)
                           ? low_count_ff + 4'd1 : 4'd0;
            if (low_count_in >= LOW_SAMPLES_ACT) begin
               low_count_in = 4'd0;
               if (mode_index_in >= solid) begin
                  mode_index_in = LOW_BATT_MODE;
                  save          = 1'b1;
               end else if (mode_index_in != 4'd0) begin
                  mode_index_in = mode_index_in - 4'd1;
                  save          = 1'b1;
               end else begin
                  powered_down_in = 1'b1;
               end
            end
         end
      end

      // levels of the mode now in force; dark while powered down
      fin = mode_lookup(mode_group_ff, mode_index_in);
      if (powered_down_in) begin
         fin    = '0;
         blinks = 3'd0;
      end else if (fin.mode_kind != KIND_BATTERY) begin
         blinks = 3'd0;
      end

      rsp_word_in.mode_number    = mode_index_in;
      rsp_word_in.main_level     = fin.main_level;
      rsp_word_in.alt_level      = fin.alt_level;
      rsp_word_in.fast_pwm       = fin.fast_pwm;
      rsp_word_in.mode_kind      = fin.mode_kind;
      rsp_word_in.blink_count    = blinks;
      rsp_word_in.config_entered = cfg;
      rsp_word_in.save_request   = save;
      rsp_word_in.shut_off       = powered_down_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         mode_group_ff     <= 1'b0;
         memory_enabled_ff <= 1'b0;
         short_limit_ff    <= SHORT_LIMIT_RESET;
         medium_limit_ff   <= MEDIUM_LIMIT_RESET;
         turbo_limit_ff    <= TURBO_LIMIT_RESET;
         low_voltage_ff    <= LOW_VOLTAGE_RESET;
         mode_index_ff     <= 4'd0;
         fast_count_ff     <= 5'd0;
         turbo_ticks_ff    <= 8'd0;
         low_count_ff      <= 4'd0;
         powered_down_ff   <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            mode_index_ff   <= mode_index_in;
            fast_count_ff   <= fast_count_in;
            turbo_ticks_ff  <= turbo_ticks_in;
            low_count_ff    <= low_count_in;
            powered_down_ff <= powered_down_in;
         end
         // the user must make csr writes only while idle; the block does not enforce it
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MODE_GROUP: begin
                  mode_group_ff <= csr_wr_data[0];
                  mode_index_ff <= 4'd0;
               end
               CSR_MEMORY_ENABLED: memory_enabled_ff <= csr_wr_data[0];
               CSR_SHORT_LIMIT:    short_limit_ff    <= csr_wr_data;
               CSR_MEDIUM_LIMIT:   medium_limit_ff   <= csr_wr_data;
               CSR_TURBO_LIMIT:    turbo_limit_ff    <= csr_wr_data;
               CSR_LOW_VOLTAGE:    low_voltage_ff    <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_word_ff  <= req_word;
      if (advance)                rsp_word_ff <= rsp_word_in;
   end

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked result");

   a_shut_off_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.shut_off) |->
         (rsp_word.main_level == 8'd0 && rsp_word.alt_level == 8'd0 && !rsp_word.fast_pwm))
      else $error("light on while shut off");

   a_config_resets_mode: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_word_in.config_entered) |=>
         (mode_index_ff == 4'd0 && fast_count_ff == 5'd0 && rsp_word.save_request))
      else $error("config entry left mode state");

endmodule

`default_nettype wire
